[design/i2cra_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helper functions of the i2c master register access unit
// no dependencies

package i2cra_pkg;

  // bus timer width and register port sizes
  localparam int DelayBits   = 16;
  localparam int HalfBits    = 16;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;

  localparam logic [HalfBits-1:0] HalfPeriodReset = 16'd250;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgHalfPeriod = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgEnable     = 2'd1;

  // request codes
  localparam logic [1:0] CmdNone  = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  // sequence step code while no transaction runs
  localparam logic [5:0] StepIdle = 6'd63;

  localparam logic [7:0] MsbMask = 8'h80;
  localparam logic [7:0] ReadBit = 8'h01;
  localparam logic [7:0] ZeroByte = 8'h00;

  // kind of one segment of a transaction
  typedef enum logic [2:0] {
    KindStart,
    KindWbyte,
    KindRbyte,
    KindStop,
    KindEnd
  } kind_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
  } out_item_t;

  // segment order of a write and of a read transaction
  function automatic kind_e seg_kind(input logic [2:0] seg, input logic is_read);
    kind_e k;
    k = KindEnd;
    if (is_read) begin
      case (seg)
        3'd0: k = KindStart;
        3'd1: k = KindWbyte;
        3'd2: k = KindWbyte;
        3'd3: k = KindStart;
        3'd4: k = KindWbyte;
        3'd5: k = KindRbyte;
        3'd6: k = KindStop;
        default: k = KindEnd;
      endcase
    end else begin
      case (seg)
        3'd0: k = KindStart;
        3'd1: k = KindWbyte;
        3'd2: k = KindWbyte;
        3'd3: k = KindWbyte;
        3'd4: k = KindStop;
        default: k = KindEnd;
      endcase
    end
    return k;
  endfunction

  // phase hold: saturate to the timer width, at least one tick
  function automatic logic [DelayBits-1:0] delay_load(input logic [HalfBits-1:0] hp);
    logic [31:0] ext;
    logic [31:0] lim;
    ext = 32'(hp);
    lim = 32'({DelayBits{1'b1}});
    if (ext > lim) ext = lim;
    if (ext == 32'd0) ext = 32'd1;
    return DelayBits'(ext);
  endfunction

endpackage

[design/i2cra_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick items, results and register writes
// depends on i2cra_pkg

interface i2cra_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] device_address;
  logic [7:0] register_address;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, command, device_address, register_address, write_data,
                  sda_in, input ready);
  modport sink (input valid, command, device_address, register_address, write_data,
                sda_in, output ready);
endinterface

interface i2cra_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       no_ack;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, read_data,
                  no_ack, input ready);
  modport sink (input valid, scl_level, sda_pull_low, busy_res, done_res, read_data,
                no_ack, output ready);
endinterface

interface i2cra_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [i2cra_pkg::CfgIdxBits-1:0]  reg_index;
  logic [i2cra_pkg::CfgDataBits-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[design/i2cra_engine.sv]
`timescale 1ns / 1ps
// bus sequencer: holds the transaction state and advances it by one tick per beat
// depends on i2cra_pkg

module i2cra_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  i2cra_pkg::in_item_t                in_item_i,
  input  logic [i2cra_pkg::HalfBits-1:0]     half_period_i,
  input  logic                               enable_i,
  output i2cra_pkg::out_item_t               res_o
);

  logic [5:0]                         step_q, step_d;
  logic [i2cra_pkg::DelayBits-1:0]    cnt_q, cnt_d;
  logic [7:0]                         shift_q, shift_d;
  logic [3:0]                         bit_q, bit_d;
  logic                               is_read_q, is_read_d;
  logic [7:0]                         dev_q, dev_d;
  logic [7:0]                         reg_q, reg_d;
  logic [7:0]                         val_q, val_d;
  logic [7:0]                         last_q, last_d;
  logic                               ack_q, ack_d;
  logic                               scl_q, scl_d;
  logic                               sda_q, sda_d;

  logic                               done;
  logic                               enter;
  logic [2:0]                         enter_seg;
  logic                               set_ph;
  logic [2:0]                         new_ph;
  logic                               apply;
  logic [2:0]                         seg_cur;
  logic [2:0]                         ph_cur;
  logic [2:0]                         ph_a;
  i2cra_pkg::kind_e                   kind_c;
  i2cra_pkg::kind_e                   kind_n;
  i2cra_pkg::kind_e                   kind_a;
  logic [7:0]                         byte_sel;

  assign seg_cur = step_q[5:3];
  assign ph_cur  = step_q[2:0];

  // next state for one tick
  always_comb begin
    step_d    = step_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    bit_d     = bit_q;
    is_read_d = is_read_q;
    dev_d     = dev_q;
    reg_d     = reg_q;
    val_d     = val_q;
    last_d    = last_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    done      = 1'b0;
    enter     = 1'b0;
    enter_seg = seg_cur;
    set_ph    = 1'b0;
    new_ph    = ph_cur;
    apply     = 1'b0;
    kind_c    = i2cra_pkg::seg_kind(seg_cur, is_read_q);
    kind_n    = i2cra_pkg::KindEnd;
    kind_a    = i2cra_pkg::KindEnd;
    ph_a      = 3'd0;
    byte_sel  = i2cra_pkg::ZeroByte;

    // enable, request latch, hold countdown or phase end
    if (!enable_i) begin
      step_d = i2cra_pkg::StepIdle;
      cnt_d  = '0;
      scl_d  = 1'b1;
      sda_d  = 1'b0;
    end else if (step_q == i2cra_pkg::StepIdle) begin
      if (in_item_i.command == i2cra_pkg::CmdRead ||
          in_item_i.command == i2cra_pkg::CmdWrite) begin
        is_read_d = (in_item_i.command == i2cra_pkg::CmdRead);
        dev_d     = in_item_i.device_address;
        reg_d     = in_item_i.register_address;
        val_d     = in_item_i.write_data;
        if (is_read_d) ack_d = 1'b0;
        enter     = 1'b1;
        enter_seg = 3'd0;
      end
    end else if (cnt_q > i2cra_pkg::DelayBits'(1)) begin
      cnt_d = cnt_q - i2cra_pkg::DelayBits'(1);
    end else begin
      case (kind_c)
        i2cra_pkg::KindStart, i2cra_pkg::KindStop: begin
          if (ph_cur >= 3'd5) begin
            enter     = 1'b1;
            enter_seg = seg_cur + 3'd1;
          end else begin
            set_ph = 1'b1;
            new_ph = ph_cur + 3'd1;
          end
        end
        i2cra_pkg::KindWbyte: begin
          if (ph_cur == 3'd2) begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 4'd1;
            set_ph  = 1'b1;
            new_ph  = (bit_d < 4'd8) ? 3'd0 : 3'd3;
          end else begin
            if (ph_cur == 3'd5 && !is_read_q) ack_d = in_item_i.sda_in;
            if (ph_cur >= 3'd6) begin
              enter     = 1'b1;
              enter_seg = seg_cur + 3'd1;
            end else begin
              set_ph = 1'b1;
              new_ph = ph_cur + 3'd1;
            end
          end
        end
        i2cra_pkg::KindRbyte: begin
          case (ph_cur)
            3'd0: begin
              shift_d = {shift_q[6:0], in_item_i.sda_in};
              set_ph  = 1'b1;
              new_ph  = 3'd1;
            end
            3'd1: begin
              bit_d  = bit_q + 4'd1;
              set_ph = 1'b1;
              new_ph = (bit_d < 4'd8) ? 3'd0 : 3'd2;
            end
            3'd2: begin
              set_ph = 1'b1;
              new_ph = 3'd3;
            end
            default: begin
              last_d    = shift_q;
              enter     = 1'b1;
              enter_seg = seg_cur + 3'd1;
            end
          endcase
        end
        default: begin
          enter     = 1'b1;
          enter_seg = seg_cur + 3'd1;
        end
      endcase
    end

    // entering a segment: load its byte or finish
    if (enter) begin
      kind_n = i2cra_pkg::seg_kind(enter_seg, is_read_d);
      if (enter_seg == 3'd1) byte_sel = dev_d;
      else if (enter_seg == 3'd2) byte_sel = reg_d;
      else if (is_read_d) byte_sel = dev_d | i2cra_pkg::ReadBit;
      else byte_sel = val_d;
      if (kind_n == i2cra_pkg::KindEnd) begin
        step_d = i2cra_pkg::StepIdle;
        cnt_d  = '0;
        done   = 1'b1;
      end else begin
        step_d  = {enter_seg, 3'd0};
        bit_d   = 4'd0;
        shift_d = (kind_n == i2cra_pkg::KindWbyte) ? byte_sel : i2cra_pkg::ZeroByte;
        apply   = 1'b1;
      end
    end

    if (set_ph) begin
      step_d = {seg_cur, new_ph};
      apply  = 1'b1;
    end

    // pin change of the new phase and its hold
    if (apply) begin
      kind_a = i2cra_pkg::seg_kind(step_d[5:3], is_read_d);
      ph_a   = step_d[2:0];
      case (kind_a)
        i2cra_pkg::KindStart: begin
          if (ph_a == 3'd0 || ph_a == 3'd2) scl_d = 1'b1;
          else if (ph_a == 3'd4) scl_d = 1'b0;
          else sda_d = (ph_a == 3'd3);
        end
        i2cra_pkg::KindStop: begin
          if (ph_a == 3'd0) scl_d = 1'b0;
          else if (ph_a == 3'd2 || ph_a == 3'd4) scl_d = 1'b1;
          else sda_d = (ph_a != 3'd5);
        end
        i2cra_pkg::KindWbyte: begin
          if (ph_a == 3'd0 || ph_a == 3'd3 || ph_a == 3'd6) scl_d = 1'b0;
          else if (ph_a == 3'd2 || ph_a == 3'd5) scl_d = 1'b1;
          else if (ph_a == 3'd1) sda_d = ((shift_d & i2cra_pkg::MsbMask) == i2cra_pkg::ZeroByte);
          else sda_d = 1'b0;
        end
        i2cra_pkg::KindRbyte: begin
          scl_d = (ph_a == 3'd0 || ph_a == 3'd2);
        end
        default: begin
          scl_d = scl_q;
        end
      endcase
      cnt_d = i2cra_pkg::delay_load(half_period_i);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= i2cra_pkg::StepIdle;
      cnt_q     <= '0;
      shift_q   <= '0;
      bit_q     <= '0;
      is_read_q <= 1'b0;
      dev_q     <= '0;
      reg_q     <= '0;
      val_q     <= '0;
      last_q    <= '0;
      ack_q     <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b0;
    end else if (step_i) begin
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      shift_q   <= shift_d;
      bit_q     <= bit_d;
      is_read_q <= is_read_d;
      dev_q     <= dev_d;
      reg_q     <= reg_d;
      val_q     <= val_d;
      last_q    <= last_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

  // result of this tick
  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_pull_low = sda_d;
    res_o.busy_res     = (step_d != i2cra_pkg::StepIdle);
    res_o.done_res     = done;
    res_o.read_data    = last_d;
    res_o.no_ack       = ack_d;
  end

endmodule

[design/i2c_master_register_access_unit.sv]
`timescale 1ns / 1ps
// an accepted tick beat is held in the input register, and its result in the result register
// throughput: one tick beat per cycle while results are taken; the sequencer state advances once per beat
// an empty input register lets a new beat in while a finished result waits to be taken
// reset: pipeline empty, bus idle with scl high and sda released, half_period 250,
// enable 0; depends on i2cra_pkg, i2cra_if and i2cra_engine

module i2c_master_register_access_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cra_in_if.sink          in_ch,
  i2cra_out_if.source       out_ch,
  i2cra_cfg_if.sink         cfg_ch
);

  logic                              s1_valid_q;
  i2cra_pkg::in_item_t               s1_item_q;
  logic                              out_valid_q;
  i2cra_pkg::out_item_t              out_item_q;
  logic [i2cra_pkg::HalfBits-1:0]    half_period_q;
  logic                              enable_q;
  logic                              advance;
  logic                              in_beat;
  i2cra_pkg::out_item_t              res;

  // handshake
  assign advance     = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || advance;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_beat) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_item_q.command          <= in_ch.command;
      s1_item_q.device_address   <= in_ch.device_address;
      s1_item_q.register_address <= in_ch.register_address;
      s1_item_q.write_data       <= in_ch.write_data;
      s1_item_q.sda_in           <= in_ch.sda_in;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cra_pkg::HalfPeriodReset;
      enable_q      <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        i2cra_pkg::CfgHalfPeriod: half_period_q <= cfg_ch.wdata;
        i2cra_pkg::CfgEnable:     enable_q      <= cfg_ch.wdata[0];
        default:                  enable_q      <= enable_q;
      endcase
    end
  end

  // sequencer
  i2cra_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .in_item_i     (s1_item_q),
    .half_period_i (half_period_q),
    .enable_i      (enable_q),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.scl_level    = out_item_q.scl_level;
  assign out_ch.sda_pull_low = out_item_q.sda_pull_low;
  assign out_ch.busy_res     = out_item_q.busy_res;
  assign out_ch.done_res     = out_item_q.done_res;
  assign out_ch.read_data    = out_item_q.read_data;
  assign out_ch.no_ack       = out_item_q.no_ack;

endmodule

[design/i2cra_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the i2c master register access unit, bound to the top level
// depends on i2c_master_register_access_unit and i2cra_if

module i2cra_assertions (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic scl_level_i,
  input logic sda_pull_low_i,
  input logic busy_res_i,
  input logic done_res_i
);

  // a finished transaction leaves the bus idle after a stop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> !busy_res_i && scl_level_i && !sda_pull_low_i)
    else $error("done beat without idle bus after stop");

  // an idle block keeps scl high and sda released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> scl_level_i && !sda_pull_low_i)
    else $error("idle beat drives the bus");

  // a sink that takes results never stalls the tick input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while results are taken");

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(busy_res_i) && $stable(done_res_i))
    else $error("stalled result beat changed");

endmodule

bind i2c_master_register_access_unit i2cra_assertions u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .scl_level_i    (out_ch.scl_level),
  .sda_pull_low_i (out_ch.sda_pull_low),
  .busy_res_i     (out_ch.busy_res),
  .done_res_i     (out_ch.done_res)
);
